### rtl/core/signed_number_glyph_renderer_assert.svh
// Assertion macros for the glyph renderer RTL.
`ifndef SIGNED_NUMBER_GLYPH_RENDERER_ASSERT_SVH
`define SIGNED_NUMBER_GLYPH_RENDERER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define SNGR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SNGR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/sngr_pkg.sv
// Types, constants and the digit font for the glyph renderer.
package sngr_pkg;

    localparam int unsigned ROW_W  = 3;
    localparam int unsigned VAL_W  = 16;
    localparam int unsigned COL_W  = 6;
    localparam int unsigned PIX_W  = 8;
    localparam int unsigned DIG_W  = 4;
    localparam int unsigned PROD_W = 33;
    localparam int unsigned RECIP_SHIFT = 19;

    localparam logic [COL_W-1:0] FIRST_DIGIT_COL = 6'd32;
    localparam logic [COL_W-1:0] CLEAR_STOP_COL  = 6'd6;
    // another digit fits only while the next glyph would start at column 8 or above
    localparam logic [COL_W-1:0] DIGIT_STOP_COL  = 6'd12;

    localparam logic [PIX_W-1:0] PX_BAR   = 8'h08;
    localparam logic [PIX_W-1:0] PX_CROSS = 8'h1c;
    localparam logic [PIX_W-1:0] PX_BLANK = 8'h00;

    // floor(x / 10) == (x * 52429) >> 19 for every 16-bit x
    localparam logic [16:0] RECIP_TEN = 17'd52429;

    typedef enum logic [2:0] {
        UPC_IDLE = 3'd0,
        UPC_SGN0 = 3'd1,
        UPC_SGN1 = 3'd2,
        UPC_SGN2 = 3'd3,
        UPC_DIG0 = 3'd4,
        UPC_DIG1 = 3'd5,
        UPC_DIG2 = 3'd6,
        UPC_CLR  = 3'd7
    } t_upc;

    typedef enum logic [1:0] {
        PXS_SIGN  = 2'd0,
        PXS_GLYPH = 2'd1,
        PXS_ZERO  = 2'd2
    } t_pix_sel;

    typedef enum logic [1:0] {
        CS_SIGN = 2'd0,
        CS_DIG  = 2'd1,
        CS_CLR  = 2'd2
    } t_col_sel;

    typedef enum logic [1:0] {
        CO_HOLD = 2'd0,
        CO_LOAD = 2'd1,
        CO_STEP = 2'd2,
        CO_DEC  = 2'd3
    } t_col_op;

    typedef enum logic [1:0] {
        J_NONE     = 2'd0,
        J_WAIT_IN  = 2'd1,
        J_MORE_DIG = 2'd2,
        J_MORE_CLR = 2'd3
    } t_jmp;

    typedef struct packed {
        logic     emit;
        t_pix_sel pix_sel;
        t_col_sel col_sel;
        logic [1:0] slot;
        t_col_op  col_op;
        logic     mul_ld;
        logic     div_ld;
        t_jmp     jmp;
        t_upc     target;
    } t_uword;

    typedef struct packed {
        logic more_dig;
        logic more_clr;
    } t_dp_flags;

    function automatic logic [PIX_W-1:0] glyph(input logic [DIG_W-1:0] d,
                                               input logic [1:0] s);
        logic [3*PIX_W-1:0] tri_cols;
        logic [PIX_W-1:0]   px;
        case (d)
            4'd0:    tri_cols = 24'h3f213f;
            4'd1:    tri_cols = 24'h223f20;
            4'd2:    tri_cols = 24'h3d2527;
            4'd3:    tri_cols = 24'h25253f;
            4'd4:    tri_cols = 24'h0f083f;
            4'd5:    tri_cols = 24'h27253d;
            4'd6:    tri_cols = 24'h3f253d;
            4'd7:    tri_cols = 24'h01013f;
            4'd8:    tri_cols = 24'h3f253f;
            4'd9:    tri_cols = 24'h2f293f;
            default: tri_cols = '0;
        endcase
        case (s)
            2'd0:    px = tri_cols[23:16];
            2'd1:    px = tri_cols[15:8];
            2'd2:    px = tri_cols[7:0];
            default: px = PX_BLANK;
        endcase
        return px;
    endfunction

endpackage

### rtl/core/signed_number_glyph_renderer.sv
// The item is taken in the idle step; the first sign step then loads the
// output register, which offers the first column transfer. The sequencer emits
// one column per cycle through a single output register while it is not stalled.
// A row at or above ROW_COUNT is accepted in the idle step and produces nothing.
// Reset (synchronous, active low) returns the sequencer to idle and empties the
// output register; payload registers are not cleared.
module signed_number_glyph_renderer #(
    parameter int unsigned ROW_COUNT = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [sngr_pkg::ROW_W-1:0]        i_row,
    input  logic signed [sngr_pkg::VAL_W-1:0] i_value,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [sngr_pkg::ROW_W-1:0]        o_out_row,
    output logic [sngr_pkg::COL_W-1:0]        o_column,
    output logic [sngr_pkg::PIX_W-1:0]        o_pixels,
    output logic                              o_last
);
    import sngr_pkg::*;

    t_upc      upc;
    t_uword    uword;
    t_dp_flags flags;
    logic      go;
    logic      out_free;
    logic      idle;
    logic      row_ok;
    logic      start;

    // Input side: the sequencer takes a new item only from its idle step, so
    // the input stall is simply "not idle". Output transfers are decoupled
    // by the datapath's output register.
    assign idle    = (upc == UPC_IDLE);
    assign o_stall = !idle;

    // Rows beyond the framebuffer are swallowed without any column writes.
    assign row_ok = ({1'b0, i_row} < 4'(ROW_COUNT));
    assign start  = i_valid && idle && row_ok;

    // Sequencer: the microprogram walks sign columns, then one three-step
    // loop per digit, then a clear loop that ends at column 6.
    sngr_useq u_useq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_out_free (out_free),
        .i_flags    (flags),
        .o_upc      (upc),
        .o_uword    (uword),
        .o_go       (go)
    );

    // Datapath: magnitude, reciprocal divide by ten spread over two steps per
    // digit, column counter, font lookup and the output register.
    sngr_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_go       (go),
        .i_uword    (uword),
        .i_row      (i_row),
        .i_value    (i_value),
        .i_stall    (i_stall),
        .o_flags    (flags),
        .o_out_free (out_free),
        .o_valid    (o_valid),
        .o_out_row  (o_out_row),
        .o_column   (o_column),
        .o_pixels   (o_pixels),
        .o_last     (o_last)
    );

endmodule

### rtl/core/sngr_useq.sv
// Microcode sequencer: step counter, control store and jump logic.
module sngr_useq (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic                i_out_free,
    input  sngr_pkg::t_dp_flags i_flags,
    output sngr_pkg::t_upc      o_upc,
    output sngr_pkg::t_uword    o_uword,
    output logic                o_go
);
    import sngr_pkg::*;

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;
    logic   go;
    logic   taken;

    function automatic t_uword ucode(input t_upc pc);
        t_uword w;
        w = '{emit: 1'b0, pix_sel: PXS_ZERO, col_sel: CS_CLR, slot: 2'd0,
              col_op: CO_HOLD, mul_ld: 1'b0, div_ld: 1'b0, jmp: J_NONE,
              target: UPC_IDLE};
        case (pc)
            UPC_IDLE: begin
                w.col_op = CO_LOAD;
                w.jmp    = J_WAIT_IN;
                w.target = UPC_IDLE;
            end
            UPC_SGN0: begin
                w.emit = 1'b1; w.pix_sel = PXS_SIGN; w.col_sel = CS_SIGN;
                w.slot = 2'd0; w.mul_ld = 1'b1;
            end
            UPC_SGN1: begin
                w.emit = 1'b1; w.pix_sel = PXS_SIGN; w.col_sel = CS_SIGN;
                w.slot = 2'd1; w.div_ld = 1'b1;
            end
            UPC_SGN2: begin
                w.emit = 1'b1; w.pix_sel = PXS_SIGN; w.col_sel = CS_SIGN;
                w.slot = 2'd2;
            end
            UPC_DIG0: begin
                w.emit = 1'b1; w.pix_sel = PXS_GLYPH; w.col_sel = CS_DIG;
                w.slot = 2'd0;
            end
            UPC_DIG1: begin
                w.emit = 1'b1; w.pix_sel = PXS_GLYPH; w.col_sel = CS_DIG;
                w.slot = 2'd1; w.mul_ld = 1'b1;
            end
            UPC_DIG2: begin
                w.emit = 1'b1; w.pix_sel = PXS_GLYPH; w.col_sel = CS_DIG;
                w.slot = 2'd2; w.div_ld = 1'b1; w.col_op = CO_STEP;
                w.jmp = J_MORE_DIG; w.target = UPC_DIG0;
            end
            UPC_CLR: begin
                w.emit = 1'b1; w.pix_sel = PXS_ZERO; w.col_sel = CS_CLR;
                w.col_op = CO_DEC; w.jmp = J_MORE_CLR; w.target = UPC_CLR;
            end
            default: begin
                w.jmp = J_NONE;
            end
        endcase
        return w;
    endfunction

    // control word and stall gating
    always_comb begin
        uw = ucode(r_upc);
        go = !uw.emit || i_out_free;
    end

    // next step
    always_comb begin
        case (uw.jmp)
            J_NONE:     taken = 1'b0;
            J_WAIT_IN:  taken = !i_start;
            J_MORE_DIG: taken = i_flags.more_dig;
            J_MORE_CLR: taken = i_flags.more_clr;
            default:    taken = 1'b0;
        endcase
        if (!go) begin
            n_upc = r_upc;
        end else if (taken) begin
            n_upc = uw.target;
        end else begin
            n_upc = t_upc'(r_upc + 3'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    assign o_upc   = r_upc;
    assign o_uword = uw;
    assign o_go    = go;

endmodule

### rtl/core/sngr_dpath.sv
// Datapath: magnitude, divide-by-ten, column counter and output register.
`include "signed_number_glyph_renderer_assert.svh"

module sngr_dpath (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_start,
    input  logic                                   i_go,
    input  sngr_pkg::t_uword                       i_uword,
    input  logic [sngr_pkg::ROW_W-1:0]             i_row,
    input  logic signed [sngr_pkg::VAL_W-1:0]      i_value,
    input  logic                                   i_stall,
    output sngr_pkg::t_dp_flags                    o_flags,
    output logic                                   o_out_free,
    output logic                                   o_valid,
    output logic [sngr_pkg::ROW_W-1:0]             o_out_row,
    output logic [sngr_pkg::COL_W-1:0]             o_column,
    output logic [sngr_pkg::PIX_W-1:0]             o_pixels,
    output logic                                   o_last
);
    import sngr_pkg::*;

    logic [ROW_W-1:0]  r_row;
    logic [VAL_W-1:0]  r_quot;
    logic              r_neg;
    logic              r_zero;
    logic [PROD_W-1:0] r_prod;
    logic [DIG_W-1:0]  r_digit;
    logic [COL_W-1:0]  r_col;

    logic              r_out_valid;
    logic [ROW_W-1:0]  r_out_row;
    logic [COL_W-1:0]  r_out_col;
    logic [PIX_W-1:0]  r_out_pix;
    logic              r_out_last;

    logic [VAL_W-1:0]  raw;
    logic [VAL_W-1:0]  mag;
    logic [13:0]       quot;
    logic [VAL_W-1:0]  rem;
    logic [PIX_W-1:0]  px;
    logic [COL_W-1:0]  col;
    logic              last;
    logic              more_dig;
    logic              more_clr;
    logic              out_free;

    // 0x8000 negates to itself, which reads as 32768 unsigned
    assign raw = i_value;
    assign mag = raw[VAL_W-1] ? (~raw + 16'd1) : raw;

    assign quot = r_prod[PROD_W-1:RECIP_SHIFT];
    assign rem  = r_quot - {quot[12:0], 3'b000} - {1'b0, quot, 1'b0};

    assign more_dig = (r_quot != '0) && (r_col >= DIGIT_STOP_COL);
    assign more_clr = (r_col != CLEAR_STOP_COL);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        case (i_uword.pix_sel)
            PXS_SIGN: begin
                if (r_zero) begin
                    px = PX_BLANK;
                end else if (i_uword.slot == 2'd1 && !r_neg) begin
                    px = PX_CROSS;
                end else begin
                    px = PX_BAR;
                end
            end
            PXS_GLYPH: px = glyph(r_digit, i_uword.slot);
            PXS_ZERO:  px = PX_BLANK;
            default:   px = PX_BLANK;
        endcase
        case (i_uword.col_sel)
            CS_SIGN: col = {4'd0, i_uword.slot};
            CS_DIG:  col = r_col + {4'd0, i_uword.slot};
            CS_CLR:  col = r_col;
            default: col = r_col;
        endcase
        last = (i_uword.col_sel == CS_CLR) && (r_col == CLEAR_STOP_COL);
    end

    // working registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= FIRST_DIGIT_COL;
        end else if (i_go) begin
            case (i_uword.col_op)
                CO_LOAD: if (i_start) begin
                    r_col <= FIRST_DIGIT_COL;
                end
                CO_STEP: r_col <= more_dig ? (r_col - 6'd4) : (r_col - 6'd1);
                CO_DEC:  r_col <= r_col - 6'd1;
                default: r_col <= r_col;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go) begin
            if (i_uword.col_op == CO_LOAD && i_start) begin
                r_row  <= i_row;
                r_quot <= mag;
                r_neg  <= raw[VAL_W-1];
                r_zero <= (raw == '0);
            end
            if (i_uword.mul_ld) begin
                r_prod <= {17'd0, r_quot} * {16'd0, RECIP_TEN};
            end
            if (i_uword.div_ld) begin
                r_quot  <= {2'b00, quot};
                r_digit <= rem[DIG_W-1:0];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_go && i_uword.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_go && i_uword.emit) begin
            r_out_row  <= r_row;
            r_out_col  <= col;
            r_out_pix  <= px;
            r_out_last <= last;
        end
    end

    assign o_flags    = '{more_dig: more_dig, more_clr: more_clr};
    assign o_out_free = out_free;
    assign o_valid    = r_out_valid;
    assign o_out_row  = r_out_row;
    assign o_column   = r_out_col;
    assign o_pixels   = r_out_pix;
    assign o_last     = r_out_last;

    `SNGR_ASSERT_IMP(a_last_at_stop, r_out_valid && r_out_last, r_out_col == CLEAR_STOP_COL, "last transfer not at column 6")
    `SNGR_ASSERT_IMP(a_digit_range, i_uword.pix_sel == PXS_GLYPH, r_digit <= 4'd9, "digit out of range")
    `SNGR_ASSERT_NXT(a_clear_walk, i_go && i_uword.col_op == CO_DEC && r_col != CLEAR_STOP_COL, r_col == $past(r_col) - 6'd1, "clear column did not step down")

endmodule
